### design/apsm_pkg.sv
// ----------------------------------------------------------------------------
// apsm_pkg: shared types and constants of the angle packet receiver
// Register indexes, reset values, widths of the shared multiply/divide unit
// and the request/result bundles that pass between the sequencer and it.
// ----------------------------------------------------------------------------
package apsm_pkg;

   // Field widths
   localparam int ANGLE_W = 8;
   localparam int MAG_W   = 7;
   localparam int PULSE_W = 12;
   localparam int BYTE_W  = 8;

   // Shared unit: 7 x 12 bit product, divided by a 7 bit divisor one bit a cycle
   localparam int MUL_A_W = 7;
   localparam int MUL_B_W = 12;
   localparam int DIV_W   = 7;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int CNT_W   = $clog2(PROD_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_ANGLE    = 3'd0,
      REG_TILT_NEUTRAL = 3'd1,
      REG_TILT_LOWEST  = 3'd2,
      REG_TILT_HIGHEST = 3'd3,
      REG_ROLL_NEUTRAL = 3'd4,
      REG_ROLL_LOWEST  = 3'd5,
      REG_ROLL_HIGHEST = 3'd6
   } csr_index_type;

   // Reset values of the registers
   localparam logic [MAG_W-1:0]   MAX_ANGLE_RST    = 7'd15;
   localparam logic [PULSE_W-1:0] TILT_NEUTRAL_RST = 12'd1700;
   localparam logic [PULSE_W-1:0] TILT_LOWEST_RST  = 12'd1500;
   localparam logic [PULSE_W-1:0] TILT_HIGHEST_RST = 12'd1900;
   localparam logic [PULSE_W-1:0] ROLL_NEUTRAL_RST = 12'd1500;
   localparam logic [PULSE_W-1:0] ROLL_LOWEST_RST  = 12'd1700;
   localparam logic [PULSE_W-1:0] ROLL_HIGHEST_RST = 12'd1300;

   localparam int SCALE_DIVISOR_DEF = 120;

   localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'hFF;
   localparam logic [MAG_W-1:0]   MAG_MAX     = 7'd127;
   localparam logic [PULSE_W-1:0] PULSE_MAX   = 12'd4095;

   // Input kinds carried on req_tuser
   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mul_a;
      logic [MUL_B_W-1:0] mul_b;
      logic [DIV_W-1:0]   divisor;
   } arith_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quot;
      logic              rem_nz;
   } arith_rsp_type;

endpackage

### design/apsm_arith.sv
// ----------------------------------------------------------------------------
// apsm_arith: shared multiply and restoring divide unit
// Registers mul_a * mul_b on start, then divides it by the divisor one
// quotient bit a cycle; pulses done with quotient and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module apsm_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  apsm_pkg::arith_req_type req,
   output apsm_pkg::arith_rsp_type rsp
);

   logic [apsm_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [apsm_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [apsm_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [apsm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [apsm_pkg::DIV_W:0]    shifted;
   logic [apsm_pkg::DIV_W+1:0]  trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[apsm_pkg::PROD_W-1]};
      trial   = {1'b0, shifted} - {2'b0, div_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (req.start) begin
         quo_in  = apsm_pkg::PROD_W'(req.mul_a * req.mul_b);
         rem_in  = '0;
         div_in  = req.divisor;
         cnt_in  = apsm_pkg::CNT_W'(apsm_pkg::PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the difference when it did not borrow
         if (!trial[apsm_pkg::DIV_W+1]) begin
            rem_in = trial[apsm_pkg::DIV_W-1:0];
         end else begin
            rem_in = shifted[apsm_pkg::DIV_W-1:0];
         end
         quo_in = {quo_ff[apsm_pkg::PROD_W-2:0], ~trial[apsm_pkg::DIV_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == apsm_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.quot   = quo_ff;
   assign rsp.rem_nz = (rem_ff != '0);

endmodule

### design/angle_packet_receiver_servo_map_top.sv
// ----------------------------------------------------------------------------
// angle_packet_receiver_servo_map_top: angle frame receiver and servo mapper
// Collects header/tilt/roll frames from a serial byte stream, decodes the
// sign-magnitude angles and maps them to saturated servo pulse widths.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_tvalid/tready    | tuser kind, tdata byte
//   rsp     | out       | rsp_tvalid/tready    | tlast frame done, tdata angles,
//           |           |                      | pulses, stale
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Timing: a tick or a byte that does not finish a frame goes from idle to the
// response state, which waits for a free output register, loads it and returns
// to idle, where req_tready is high again. The byte that finishes a frame runs
// four jobs on the shared multiply/divide unit (two angle decodes, two pulse
// maps), each a start pulse, operand load and 19 quotient bits.
// One beat is in flight at a time: req_tready is high only while idle.
// Reset is synchronous; it restores the register defaults and a stale state.
// A stalled rsp side holds the finished beat; the next item may still enter
// and its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module angle_packet_receiver_servo_map_top #(
   parameter int SCALE_DIVISOR = apsm_pkg::SCALE_DIVISOR_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] rx_byte
   input  logic                              req_tuser,  // [0] req_type
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // [7:0] tilt_deg,
                                                         // [15:8] roll_deg,
                                                         // [27:16] tilt_pulse,
                                                         // [39:28] roll_pulse,
                                                         // [40] stale, rest 0
   output logic                              rsp_tlast,  // frame_done
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [apsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apsm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam logic [apsm_pkg::DIV_W-1:0] ScaleDiv = apsm_pkg::DIV_W'(SCALE_DIVISOR);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DEC_TILT = 6'b000010,
      ST_DEC_ROLL = 6'b000100,
      ST_MAP_TILT = 6'b001000,
      ST_MAP_ROLL = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [apsm_pkg::MAG_W-1:0]   max_angle_ff, max_angle_in;
   logic [apsm_pkg::PULSE_W-1:0] tilt_neutral_ff, tilt_neutral_in;
   logic [apsm_pkg::PULSE_W-1:0] tilt_lowest_ff, tilt_lowest_in;
   logic [apsm_pkg::PULSE_W-1:0] tilt_highest_ff, tilt_highest_in;
   logic [apsm_pkg::PULSE_W-1:0] roll_neutral_ff, roll_neutral_in;
   logic [apsm_pkg::PULSE_W-1:0] roll_lowest_ff, roll_lowest_in;
   logic [apsm_pkg::PULSE_W-1:0] roll_highest_ff, roll_highest_in;

   // receiver state
   logic                          in_frame_ff, in_frame_in;
   logic                          count_ff, count_in;
   logic [apsm_pkg::BYTE_W-1:0]   tilt_raw_ff, tilt_raw_in;
   logic [apsm_pkg::BYTE_W-1:0]   roll_raw_ff, roll_raw_in;
   logic [apsm_pkg::ANGLE_W-1:0]  tilt_angle_ff, tilt_angle_in;
   logic [apsm_pkg::ANGLE_W-1:0]  roll_angle_ff, roll_angle_in;
   logic [apsm_pkg::PULSE_W-1:0]  tilt_pulse_ff, tilt_pulse_in;
   logic [apsm_pkg::PULSE_W-1:0]  roll_pulse_ff, roll_pulse_in;
   logic                          stale_ff, stale_in;
   logic                          done_ff, done_in;
   logic                          start_ff, start_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [47:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   apsm_pkg::arith_req_type       arith_req;
   apsm_pkg::arith_rsp_type       arith_rsp;

   // operand selection for the current job
   logic                          map_roll;
   logic [apsm_pkg::BYTE_W-1:0]   cur_raw;
   logic [apsm_pkg::ANGLE_W-1:0]  cur_angle;
   logic [apsm_pkg::PULSE_W-1:0]  cur_neutral;
   logic [apsm_pkg::PULSE_W-1:0]  cur_lowest;
   logic [apsm_pkg::PULSE_W-1:0]  cur_highest;
   logic [apsm_pkg::PULSE_W:0]    span;
   logic [apsm_pkg::PULSE_W:0]    span_neg;
   logic [apsm_pkg::PULSE_W-1:0]  span_abs;
   logic [apsm_pkg::MAG_W-1:0]    angle_abs;
   logic                          map_neg;

   // result shaping
   logic [apsm_pkg::MAG_W-1:0]    dec_mag;
   logic [apsm_pkg::ANGLE_W-1:0]  dec_angle;
   logic [apsm_pkg::PROD_W:0]     q_adj;
   logic signed [apsm_pkg::PROD_W+2:0] p_sum;
   logic [apsm_pkg::PULSE_W-1:0]  p_sat;
   logic                          req_beat;
   logic                          rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // operand muxes: roll in the roll states, tilt otherwise
   always_comb begin
      map_roll    = (state_ff == ST_MAP_ROLL);
      cur_raw     = (state_ff == ST_DEC_ROLL) ? roll_raw_ff : tilt_raw_ff;
      cur_angle   = map_roll ? roll_angle_ff   : tilt_angle_ff;
      cur_neutral = map_roll ? roll_neutral_ff : tilt_neutral_ff;
      cur_lowest  = map_roll ? roll_lowest_ff  : tilt_lowest_ff;
      cur_highest = map_roll ? roll_highest_ff : tilt_highest_ff;

      // negative angles scale by neutral - lowest, positive by highest - neutral
      if (cur_angle[apsm_pkg::ANGLE_W-1]) begin
         span = {1'b0, cur_neutral} - {1'b0, cur_lowest};
      end else begin
         span = {1'b0, cur_highest} - {1'b0, cur_neutral};
      end
      span_neg  = -span;
      span_abs  = span[apsm_pkg::PULSE_W] ? span_neg[apsm_pkg::PULSE_W-1:0]
                                          : span[apsm_pkg::PULSE_W-1:0];
      angle_abs = cur_angle[apsm_pkg::ANGLE_W-1]
                ? apsm_pkg::MAG_W'(-cur_angle) : cur_angle[apsm_pkg::MAG_W-1:0];
      map_neg   = cur_angle[apsm_pkg::ANGLE_W-1] ^ span[apsm_pkg::PULSE_W];

      arith_req.start = start_ff;
      if (state_ff == ST_DEC_TILT || state_ff == ST_DEC_ROLL) begin
         arith_req.mul_a   = max_angle_ff;
         arith_req.mul_b   = apsm_pkg::MUL_B_W'(cur_raw[apsm_pkg::MAG_W-1:0]);
         arith_req.divisor = ScaleDiv;
      end else begin
         arith_req.mul_a   = angle_abs;
         arith_req.mul_b   = span_abs;
         arith_req.divisor = max_angle_ff;
      end
   end

   // decode result: saturate the magnitude, apply the sign bit
   always_comb begin
      dec_mag   = (arith_rsp.quot > apsm_pkg::PROD_W'(apsm_pkg::MAG_MAX))
                ? apsm_pkg::MAG_MAX : arith_rsp.quot[apsm_pkg::MAG_W-1:0];
      dec_angle = cur_raw[apsm_pkg::BYTE_W-1] ? -{1'b0, dec_mag} : {1'b0, dec_mag};
   end

   // map result: floor toward minus infinity, then clamp into the pulse range
   always_comb begin
      q_adj = {1'b0, arith_rsp.quot}
            + apsm_pkg::PROD_W'(map_neg && arith_rsp.rem_nz);
      if (map_neg) begin
         p_sum = $signed({{(apsm_pkg::PROD_W + 3 - apsm_pkg::PULSE_W){1'b0}}, cur_neutral})
               - $signed({2'b00, q_adj});
      end else begin
         p_sum = $signed({{(apsm_pkg::PROD_W + 3 - apsm_pkg::PULSE_W){1'b0}}, cur_neutral})
               + $signed({2'b00, q_adj});
      end
      if (cur_angle == '0) begin
         p_sat = cur_neutral;
      end else if (p_sum < 0) begin
         p_sat = '0;
      end else if (p_sum > $signed((apsm_pkg::PROD_W + 3)'(apsm_pkg::PULSE_MAX))) begin
         p_sat = apsm_pkg::PULSE_MAX;
      end else begin
         p_sat = p_sum[apsm_pkg::PULSE_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      max_angle_in    = max_angle_ff;
      tilt_neutral_in = tilt_neutral_ff;
      tilt_lowest_in  = tilt_lowest_ff;
      tilt_highest_in = tilt_highest_ff;
      roll_neutral_in = roll_neutral_ff;
      roll_lowest_in  = roll_lowest_ff;
      roll_highest_in = roll_highest_ff;
      in_frame_in     = in_frame_ff;
      count_in        = count_ff;
      tilt_raw_in     = tilt_raw_ff;
      roll_raw_in     = roll_raw_ff;
      tilt_angle_in   = tilt_angle_ff;
      roll_angle_in   = roll_angle_ff;
      tilt_pulse_in   = tilt_pulse_ff;
      roll_pulse_in   = roll_pulse_ff;
      stale_in        = stale_ff;
      done_in         = done_ff;
      start_in        = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;

      // register writes; indexes past the list are dropped
      if (csr_valid) begin
         unique case (csr_index)
            apsm_pkg::REG_MAX_ANGLE:    max_angle_in    = csr_data[apsm_pkg::MAG_W-1:0];
            apsm_pkg::REG_TILT_NEUTRAL: tilt_neutral_in = csr_data;
            apsm_pkg::REG_TILT_LOWEST:  tilt_lowest_in  = csr_data;
            apsm_pkg::REG_TILT_HIGHEST: tilt_highest_in = csr_data;
            apsm_pkg::REG_ROLL_NEUTRAL: roll_neutral_in = csr_data;
            apsm_pkg::REG_ROLL_LOWEST:  roll_lowest_in  = csr_data;
            apsm_pkg::REG_ROLL_HIGHEST: roll_highest_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               done_in  = 1'b0;
               state_in = ST_RESP;
               if (req_tuser == apsm_pkg::KIND_TICK) begin
                  stale_in = 1'b1;
               end else if (req_tdata == apsm_pkg::HEADER_BYTE) begin
                  in_frame_in = 1'b1;
                  count_in    = 1'b0;
               end else if (in_frame_ff) begin
                  if (!count_ff) begin
                     tilt_raw_in = req_tdata;
                     count_in    = 1'b1;
                  end else begin
                     // last byte of the frame: start the decode chain
                     roll_raw_in = req_tdata;
                     start_in    = 1'b1;
                     state_in    = ST_DEC_TILT;
                  end
               end
            end
         end
         ST_DEC_TILT: begin
            if (arith_rsp.done) begin
               tilt_angle_in = dec_angle;
               start_in      = 1'b1;
               state_in      = ST_DEC_ROLL;
            end
         end
         ST_DEC_ROLL: begin
            if (arith_rsp.done) begin
               roll_angle_in = dec_angle;
               start_in      = 1'b1;
               state_in      = ST_MAP_TILT;
            end
         end
         ST_MAP_TILT: begin
            if (arith_rsp.done) begin
               tilt_pulse_in = p_sat;
               start_in      = 1'b1;
               state_in      = ST_MAP_ROLL;
            end
         end
         ST_MAP_ROLL: begin
            if (arith_rsp.done) begin
               roll_pulse_in = p_sat;
               stale_in      = 1'b0;
               in_frame_in   = 1'b0;
               count_in      = 1'b0;
               done_in       = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            // hold until the output register frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = done_ff;
               rsp_data_in  = {7'b0, stale_ff, roll_pulse_ff, tilt_pulse_ff,
                               roll_angle_ff, tilt_angle_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tilt_raw_ff <= tilt_raw_in;
      roll_raw_ff <= roll_raw_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      done_ff     <= done_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_angle_ff    <= apsm_pkg::MAX_ANGLE_RST;
         tilt_neutral_ff <= apsm_pkg::TILT_NEUTRAL_RST;
         tilt_lowest_ff  <= apsm_pkg::TILT_LOWEST_RST;
         tilt_highest_ff <= apsm_pkg::TILT_HIGHEST_RST;
         roll_neutral_ff <= apsm_pkg::ROLL_NEUTRAL_RST;
         roll_lowest_ff  <= apsm_pkg::ROLL_LOWEST_RST;
         roll_highest_ff <= apsm_pkg::ROLL_HIGHEST_RST;
         in_frame_ff     <= 1'b0;
         count_ff        <= 1'b0;
         tilt_angle_ff   <= '0;
         roll_angle_ff   <= '0;
         tilt_pulse_ff   <= apsm_pkg::TILT_NEUTRAL_RST;
         roll_pulse_ff   <= apsm_pkg::ROLL_NEUTRAL_RST;
         stale_ff        <= 1'b1;
         start_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_angle_ff    <= max_angle_in;
         tilt_neutral_ff <= tilt_neutral_in;
         tilt_lowest_ff  <= tilt_lowest_in;
         tilt_highest_ff <= tilt_highest_in;
         roll_neutral_ff <= roll_neutral_in;
         roll_lowest_ff  <= roll_lowest_in;
         roll_highest_ff <= roll_highest_in;
         in_frame_ff     <= in_frame_in;
         count_ff        <= count_in;
         tilt_angle_ff   <= tilt_angle_in;
         roll_angle_ff   <= roll_angle_in;
         tilt_pulse_ff   <= tilt_pulse_in;
         roll_pulse_ff   <= roll_pulse_in;
         stale_ff        <= stale_in;
         start_ff        <= start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   apsm_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arith_req),
      .rsp   (arith_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the angle packet receiver and servo mapper
// Sends serial bytes and stale ticks and predicts every result beat in the
// bench. A directed table covers reset, the extremes and the frame corner
// cases. Random phases follow with fresh register settings, mostly
// well-formed frames, and random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD   = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 200;
   localparam int SETTLE_TICKS = 100;       // above the slowest frame latency
   localparam int LIMIT_NS     = 20_000_000;

   // Fields of one result beat: frame_done from rsp_tlast, the rest from rsp_tdata
   typedef struct packed {
      logic                          frame_done;
      logic signed [7:0]             tilt_deg;
      logic signed [7:0]             roll_deg;
      logic [apsm_pkg::PULSE_W-1:0]  tilt_pulse;
      logic [apsm_pkg::PULSE_W-1:0]  roll_pulse;
      logic                          stale;
   } servo_result_type;

   // Directed rows: a byte, a tick, or a new full-scale angle
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_TICK,
      ROW_MAX_ANGLE
   } row_act_type;

   typedef struct {
      row_act_type      act;
      logic [11:0]      value;
      bit               typed;
      servo_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = 8'h00;
   logic                            req_tuser  = apsm_pkg::KIND_BYTE;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [47:0]                     rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [apsm_pkg::CSR_IDX_W-1:0]  csr_index  = apsm_pkg::REG_MAX_ANGLE;
   logic [apsm_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   angle_packet_receiver_servo_map_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register copy held by the bench, starting at the reset defaults
   logic [apsm_pkg::MAG_W-1:0]   cfg_max_angle    = apsm_pkg::MAX_ANGLE_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_tilt_neutral = apsm_pkg::TILT_NEUTRAL_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_tilt_lowest  = apsm_pkg::TILT_LOWEST_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_tilt_highest = apsm_pkg::TILT_HIGHEST_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_roll_neutral = apsm_pkg::ROLL_NEUTRAL_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_roll_lowest  = apsm_pkg::ROLL_LOWEST_RST;
   logic [apsm_pkg::PULSE_W-1:0] cfg_roll_highest = apsm_pkg::ROLL_HIGHEST_RST;

   // Receiver state as the bench sees it
   bit                           rx_in_frame    = 1'b0;
   bit                           rx_have_tilt   = 1'b0;
   logic [7:0]                   rx_tilt_byte   = 8'h00;
   logic signed [7:0]            cur_tilt_deg   = '0;
   logic signed [7:0]            cur_roll_deg   = '0;
   logic [apsm_pkg::PULSE_W-1:0] cur_tilt_pulse = apsm_pkg::TILT_NEUTRAL_RST;
   logic [apsm_pkg::PULSE_W-1:0] cur_roll_pulse = apsm_pkg::ROLL_NEUTRAL_RST;
   bit                           cur_stale      = 1'b1;
   bit                           byte_ignored;

   servo_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   servo_result_type head_result;

   bit idle_on     = 1'b1;
   int stall_left  = 0;
   int fail_count  = 0;
   int beats_in    = 0;
   int useful_in   = 0;
   int ticks_in    = 0;
   int frames_out  = 0;
   int beats_out   = 0;
   int settings    = 0;
   int angle_pick[5] = '{15, 1, 127, 0, 90};

   // Sign-magnitude byte to whole degrees, scaled by the full-scale angle
   function automatic logic signed [7:0] decode_deg(logic [7:0] raw);
      int mag;
      mag = int'(cfg_max_angle) * int'(raw[6:0]) / apsm_pkg::SCALE_DIVISOR_DEF;
      if (mag > int'(apsm_pkg::MAG_MAX))
         mag = int'(apsm_pkg::MAG_MAX);
      return raw[7] ? 8'(-mag) : 8'(mag);
   endfunction

   // Degrees to a pulse width: separate spans above and below neutral,
   // quotient floored toward minus infinity, then clamped to 12 bits
   function automatic logic [apsm_pkg::PULSE_W-1:0] map_pulse(
         int deg, logic [apsm_pkg::PULSE_W-1:0] neutral,
         logic [apsm_pkg::PULSE_W-1:0] lowest, logic [apsm_pkg::PULSE_W-1:0] highest);
      int span;
      int num;
      int quo;
      int width;
      width = int'(neutral);
      if (deg != 0 && cfg_max_angle != 0) begin
         span = (deg > 0) ? int'(highest) - int'(neutral) : int'(neutral) - int'(lowest);
         num  = deg * span;
         quo  = num / int'(cfg_max_angle);
         if (num % int'(cfg_max_angle) != 0 && num < 0)
            quo--;
         width += quo;
      end
      if (width < 0)
         width = 0;
      if (width > int'(apsm_pkg::PULSE_MAX))
         width = int'(apsm_pkg::PULSE_MAX);
      return 12'(width);
   endfunction

   // Advance the receiver by one accepted beat and return the result it gives
   function automatic servo_result_type step_receiver(apsm_pkg::req_kind_type kind,
                                                      logic [7:0] rx);
      servo_result_type r;
      r.frame_done = 1'b0;
      byte_ignored = 1'b0;
      if (kind == apsm_pkg::KIND_TICK) begin
         cur_stale = 1'b1;
      end else if (rx == apsm_pkg::HEADER_BYTE) begin
         rx_in_frame  = 1'b1;
         rx_have_tilt = 1'b0;
      end else if (rx_in_frame) begin
         if (!rx_have_tilt) begin
            rx_tilt_byte = rx;
            rx_have_tilt = 1'b1;
         end else begin
            cur_tilt_deg   = decode_deg(rx_tilt_byte);
            cur_roll_deg   = decode_deg(rx);
            cur_tilt_pulse = map_pulse(int'(cur_tilt_deg), cfg_tilt_neutral,
                                       cfg_tilt_lowest, cfg_tilt_highest);
            cur_roll_pulse = map_pulse(int'(cur_roll_deg), cfg_roll_neutral,
                                       cfg_roll_lowest, cfg_roll_highest);
            cur_stale    = 1'b0;
            rx_in_frame  = 1'b0;
            rx_have_tilt = 1'b0;
            r.frame_done = 1'b1;
         end
      end else begin
         byte_ignored = 1'b1;
      end
      r.tilt_deg   = cur_tilt_deg;
      r.roll_deg   = cur_roll_deg;
      r.tilt_pulse = cur_tilt_pulse;
      r.roll_pulse = cur_roll_pulse;
      r.stale      = cur_stale;
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (!idle_on)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   // Pulse settings lean on the rails so saturation gets exercised
   function automatic logic [apsm_pkg::PULSE_W-1:0] pick_pulse();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return apsm_pkg::PULSE_MAX;
      return apsm_pkg::PULSE_W'($urandom_range(0, 4095));
   endfunction

   // Angle bytes: sign and magnitude extremes, otherwise anything but a header
   function automatic logic [7:0] pick_angle_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'h7F;
         2:       return 8'h80;
         3:       return 8'hFE;
         default: return 8'($urandom_range(0, 254));
      endcase
   endfunction

   function automatic servo_result_type outcome(bit done, int tilt, int roll, int tp, int rp,
                                                bit stale);
      servo_result_type r;
      r.frame_done = done;
      r.tilt_deg   = 8'(tilt);
      r.roll_deg   = 8'(roll);
      r.tilt_pulse = 12'(tp);
      r.roll_pulse = 12'(rp);
      r.stale      = stale;
      return r;
   endfunction

   function automatic void add_row(row_act_type act, logic [11:0] value, bit typed = 1'b0,
                                   servo_result_type want = '0);
      stim_row_type row;
      row.act   = act;
      row.value = value;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Hold the beat on the request channel until it is taken, then predict it.
   // Typed rows replace the predicted result but still advance the state.
   task automatic send_item(input apsm_pkg::req_kind_type kind, input logic [7:0] rx,
                            input bit typed = 1'b0, input servo_result_type want = '0);
      int gap;
      servo_result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = rx;
      do @(posedge clock); while (!req_tready);
      predicted = step_receiver(kind, rx);
      pending_results.push_back(typed ? want : predicted);
      beats_in++;
      if (kind == apsm_pkg::KIND_TICK)
         ticks_in++;
      if (!byte_ignored)
         useful_in++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input apsm_pkg::csr_index_type idx, input logic [11:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         apsm_pkg::REG_MAX_ANGLE:    cfg_max_angle    = value[apsm_pkg::MAG_W-1:0];
         apsm_pkg::REG_TILT_NEUTRAL: cfg_tilt_neutral = value;
         apsm_pkg::REG_TILT_LOWEST:  cfg_tilt_lowest  = value;
         apsm_pkg::REG_TILT_HIGHEST: cfg_tilt_highest = value;
         apsm_pkg::REG_ROLL_NEUTRAL: cfg_roll_neutral = value;
         apsm_pkg::REG_ROLL_LOWEST:  cfg_roll_lowest  = value;
         apsm_pkg::REG_ROLL_HIGHEST: cfg_roll_highest = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random traffic: mostly whole frames with random angles, some with a tick
   // in the middle; the rest restarted frames, lone ticks and line noise.
   task automatic run_random(input int quota);
      int target;
      int roll;
      target = useful_in + quota;
      while (useful_in < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            send_item(apsm_pkg::KIND_BYTE, apsm_pkg::HEADER_BYTE);
            send_item(apsm_pkg::KIND_BYTE, pick_angle_byte());
            if ($urandom_range(0, 9) == 0)
               send_item(apsm_pkg::KIND_TICK, 8'($urandom));
            send_item(apsm_pkg::KIND_BYTE, pick_angle_byte());
         end else if (roll < 82) begin
            send_item(apsm_pkg::KIND_BYTE, apsm_pkg::HEADER_BYTE);
            send_item(apsm_pkg::KIND_BYTE, pick_angle_byte());
            send_item(apsm_pkg::KIND_BYTE, apsm_pkg::HEADER_BYTE);
         end else if (roll < 90) begin
            send_item(apsm_pkg::KIND_TICK, 8'($urandom));
         end else begin
            send_item(apsm_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Result side: random back-pressure, mostly short, some long, none at all
   // while idling is switched off for a phase.
   always @(negedge clock) begin
      if (!idle_on) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         rsp_tready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // Compare every taken result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out++;
         if (rsp_tlast)
            frames_out++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: tdata %h tlast %b",
                   rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            head_result = pending_results.pop_front();
            check_field("frame_done", int'(head_result.frame_done), int'(rsp_tlast));
            check_field("tilt_deg", int'(head_result.tilt_deg),
                        int'($signed(rsp_tdata[7:0])));
            check_field("roll_deg", int'(head_result.roll_deg),
                        int'($signed(rsp_tdata[15:8])));
            check_field("tilt_pulse", int'(head_result.tilt_pulse), int'(rsp_tdata[27:16]));
            check_field("roll_pulse", int'(head_result.roll_pulse), int'(rsp_tdata[39:28]));
            check_field("stale", int'(head_result.stale), int'(rsp_tdata[40]));
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [11:0] reg_vals[7];

      // Reset values at first: 15 degrees full scale, tilt 1500/1700/1900,
      // roll 1700/1500/1300 (roll is wired inverted).
      add_row(ROW_TICK, 12'h0A5, 1'b1, outcome(0, 0, 0, 1700, 1500, 1));
      // byte before any header: dropped, held values reported
      add_row(ROW_BYTE, 12'h000, 1'b1, outcome(0, 0, 0, 1700, 1500, 1));
      add_row(ROW_BYTE, 12'h0FF, 1'b1, outcome(0, 0, 0, 1700, 1500, 1));
      add_row(ROW_BYTE, 12'h07F, 1'b1, outcome(0, 0, 0, 1700, 1500, 1));
      // largest positive magnitude on both axes: full-scale pulses
      add_row(ROW_BYTE, 12'h07F, 1'b1, outcome(1, 15, 15, 1900, 1300, 0));
      // stray bytes after a finished frame must not finish it again
      add_row(ROW_BYTE, 12'h005, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      add_row(ROW_BYTE, 12'h006, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      // a header in the middle of a frame restarts it
      add_row(ROW_BYTE, 12'h0FF, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      add_row(ROW_BYTE, 12'h081, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      add_row(ROW_BYTE, 12'h0FF, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      // negative zero tilt, largest negative roll
      add_row(ROW_BYTE, 12'h080, 1'b1, outcome(0, 15, 15, 1900, 1300, 0));
      add_row(ROW_BYTE, 12'h0FE, 1'b1, outcome(1, 0, -15, 1700, 1700, 0));
      // tick inside a frame carrying a header pattern: sets stale only
      add_row(ROW_BYTE, 12'h0FF);
      add_row(ROW_BYTE, 12'h040);
      add_row(ROW_TICK, 12'h0FF);
      add_row(ROW_BYTE, 12'h000);
      // zero full scale: every angle decodes to zero, pulses sit at neutral
      add_row(ROW_MAX_ANGLE, 12'd0);
      add_row(ROW_BYTE, 12'h0FF);
      add_row(ROW_BYTE, 12'h07F);
      add_row(ROW_BYTE, 12'h080, 1'b1, outcome(1, 0, 0, 1700, 1500, 0));
      // widest full scale: decoded magnitude overflows and clamps at 127
      add_row(ROW_MAX_ANGLE, 12'd127);
      add_row(ROW_BYTE, 12'h0FF);
      add_row(ROW_BYTE, 12'h07F);
      add_row(ROW_BYTE, 12'h0FE, 1'b1, outcome(1, 127, -127, 1900, 1700, 0));

      // Synchronous reset, released on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settings = 1;

      // Walk the directed rows; full-scale changes wait for an idle block
      foreach (directed_rows[i]) begin
         case (directed_rows[i].act)
            ROW_BYTE:
               send_item(apsm_pkg::KIND_BYTE, directed_rows[i].value[7:0],
                         directed_rows[i].typed, directed_rows[i].want);
            ROW_TICK:
               send_item(apsm_pkg::KIND_TICK, directed_rows[i].value[7:0],
                         directed_rows[i].typed, directed_rows[i].want);
            ROW_MAX_ANGLE: begin
               drain();
               write_reg(apsm_pkg::REG_MAX_ANGLE, directed_rows[i].value);
               settings++;
            end
            default: ;
         endcase
      end

      // Random phases: rewrite every register with the block idle, then run.
      // Phase 0 restores the defaults; later ones sweep the full-scale angle
      // through its extremes and throw pulse limits at the rails. Every third
      // phase runs without idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase == 0) begin
            reg_vals = '{12'(apsm_pkg::MAX_ANGLE_RST), apsm_pkg::TILT_NEUTRAL_RST,
                         apsm_pkg::TILT_LOWEST_RST, apsm_pkg::TILT_HIGHEST_RST,
                         apsm_pkg::ROLL_NEUTRAL_RST, apsm_pkg::ROLL_LOWEST_RST,
                         apsm_pkg::ROLL_HIGHEST_RST};
         end else begin
            reg_vals[0] = (phase < 5) ? 12'(angle_pick[phase])
                                      : 12'($urandom_range(1, 90));
            for (int k = 1; k < 7; k++)
               reg_vals[k] = pick_pulse();
         end
         for (int k = 0; k < 7; k++)
            write_reg(apsm_pkg::csr_index_type'(k), reg_vals[k]);
         settings++;
         idle_on = (phase % 3 != 2);
         run_random(PHASE_BEATS);
      end

      // Let the last results drain, then give the block its latency once more
      drain();
      idle_on = 1'b1;
      repeat (SETTLE_TICKS) @(negedge clock);

      $display("Sent %0d request beats (%0d ticks) under %0d register settings,",
               beats_in, ticks_in, settings);
      $display("checked %0d result beats carrying %0d finished frames.",
               beats_out, frames_out);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
